FILE: sv/lbc_pkg.sv
// Package for the byte-budget LRU block cache.
// Holds the operation, status, state and update codes; no dependencies.
package lbc_pkg;

  localparam int ENTRIES_DEFAULT     = 16;
  localparam int HANDLE_BITS_DEFAULT = 16;
  localparam int OP_W                = 2;
  localparam int STATUS_W            = 3;
  localparam int COUNT_W             = 5;
  localparam int WORD_W              = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_INSERTED = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_REJECTED = 3'd4,
    ST_ERASED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVICT_CHK,
    S_EVICT_DROP,
    S_PLACE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PROMOTE,
    ACT_DROP,
    ACT_PLACE
  } act_t;

endpackage

FILE: sv/lbc_if.sv
// Channel interfaces of the block cache: request, response and configuration.
// Depends on lbc_pkg for field widths.
interface lbc_req_if import lbc_pkg::*; #(parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT);
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [WORD_W-1:0]      table_id;
  logic [WORD_W-1:0]      block_index;
  logic [HANDLE_BITS-1:0] block_handle;
  logic [WORD_W-1:0]      charge;
  modport source (output valid, op, table_id, block_index, block_handle, charge,
                  input ready);
  modport sink (input valid, op, table_id, block_index, block_handle, charge,
                output ready);
endinterface

interface lbc_rsp_if import lbc_pkg::*; #(parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT);
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [HANDLE_BITS-1:0] hit_handle;
  logic [COUNT_W-1:0]     evicted_count;
  logic [WORD_W-1:0]      charge_total;
  modport source (output valid, status, hit_handle, evicted_count, charge_total,
                  input ready);
  modport sink (input valid, status, hit_handle, evicted_count, charge_total,
                output ready);
endinterface

interface lbc_cfg_if import lbc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/lru_block_cache_byte_charge.sv
// Byte-budget LRU block cache. One request is worked on at a time and its response is
// held in an output register, so a new request is taken while the last response waits.
// The entry memory has one read port and gives one entry per cycle. A lookup miss or an
// erase walks every entry, a lookup hit or an insert of a key already present stops at
// the matching slot, an insert of a new key walks every entry and then evicts least
// recently used entries as needed before it places the new one, and a disabled cache,
// a rejected insert or an unused operation answers without a scan. There is no clearing
// pass after reset.
// Depends on lbc_pkg, lbc_if, lbc_mem and lbc_ctrl.
module lru_block_cache_byte_charge import lbc_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEFAULT,
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  lbc_cfg_if.sink   cfg,
  lbc_req_if.sink   req,
  lbc_rsp_if.source rsp
);

  localparam int IW = $clog2(ENTRIES);
  localparam int MW = 3 * WORD_W + HANDLE_BITS;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  lbc_ctrl #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lbc_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: sv/lbc_mem.sv
// Entry memory of the block cache: one write port, one read port, registered read.
// No dependencies.
module lbc_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lbc_ctrl.sv
// Sequencer of the block cache: key scan, eviction, placement and recency ranks.
// Depends on lbc_pkg, the channel interfaces and an external lbc_mem.
module lbc_ctrl import lbc_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEFAULT,
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT,
  localparam int IW = $clog2(ENTRIES),
  localparam int MW = 3 * WORD_W + HANDLE_BITS
) (
  input  logic          clk,
  input  logic          rst,
  lbc_cfg_if.sink       cfg,
  lbc_req_if.sink       req,
  lbc_rsp_if.source     rsp,
  output logic          mem_we,
  output logic [IW-1:0] mem_waddr,
  output logic [MW-1:0] mem_wdata,
  output logic [IW-1:0] mem_raddr,
  input  logic [MW-1:0] mem_rdata
);

  localparam int CW = $clog2(ENTRIES + 1);

  state_t                 state, state_next;
  logic [WORD_W-1:0]      capacity;
  logic [ENTRIES-1:0]     valid, valid_next;
  logic [IW-1:0]          rank [ENTRIES];
  logic [IW-1:0]          rank_next [ENTRIES];
  logic [CW-1:0]          count, count_next;
  logic [WORD_W-1:0]      resident, resident_next;
  logic [IW-1:0]          ptr, ptr_next;
  logic [OP_W-1:0]        op_q, op_q_next;
  logic [WORD_W-1:0]      table_q, table_q_next;
  logic [WORD_W-1:0]      offset_q, offset_q_next;
  logic [HANDLE_BITS-1:0] handle_q, handle_q_next;
  logic [WORD_W-1:0]      charge_q, charge_q_next;
  status_t                status_q, status_q_next;
  logic [HANDLE_BITS-1:0] hit_q, hit_q_next;
  logic [COUNT_W-1:0]     removed, removed_next;
  logic                   out_valid, out_valid_next;
  logic [STATUS_W-1:0]    out_status, out_status_next;
  logic [HANDLE_BITS-1:0] out_hit, out_hit_next;
  logic [COUNT_W-1:0]     out_removed, out_removed_next;
  logic [WORD_W-1:0]      out_total, out_total_next;

  act_t                   act;
  logic [IW-1:0]          tgt;
  logic [IW-1:0]          tgt_rank;
  logic [IW-1:0]          lru_idx;
  logic [IW-1:0]          free_idx;
  logic [WORD_W-1:0]      rd_table, rd_offset, rd_charge;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   over;

  assign rd_charge = mem_rdata[WORD_W-1:0];
  assign rd_handle = mem_rdata[WORD_W +: HANDLE_BITS];
  assign rd_offset = mem_rdata[WORD_W+HANDLE_BITS +: WORD_W];
  assign rd_table  = mem_rdata[2*WORD_W+HANDLE_BITS +: WORD_W];

  assign cfg.ready         = 1'b1;
  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.hit_handle    = out_hit;
  assign rsp.evicted_count = out_removed;
  assign rsp.charge_total  = out_total;

  assign mem_waddr = free_idx;
  assign mem_wdata = {table_q, offset_q, handle_q, charge_q};
  assign over = ({1'b0, resident} + {1'b0, charge_q}) > {1'b0, capacity};

  always_comb begin
    lru_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && rank[i] == IW'(count - CW'(1))) begin
        lru_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    tgt_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tgt == IW'(i)) begin
        tgt_rank = tgt_rank | rank[i];
      end
    end
  end

  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
      case (act)
        ACT_PROMOTE: begin
          if (tgt == IW'(i)) begin
            rank_next[i] = '0;
          end else if (valid[i] && rank[i] < tgt_rank) begin
            rank_next[i] = rank[i] + IW'(1);
          end
        end
        ACT_DROP: begin
          if (tgt == IW'(i)) begin
            valid_next[i] = 1'b0;
          end else if (valid[i] && rank[i] > tgt_rank) begin
            rank_next[i] = rank[i] - IW'(1);
          end
        end
        ACT_PLACE: begin
          if (tgt == IW'(i)) begin
            valid_next[i] = 1'b1;
            rank_next[i]  = '0;
          end else if (valid[i]) begin
            rank_next[i] = rank[i] + IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    case (act)
      ACT_DROP:  count_next = count - CW'(1);
      ACT_PLACE: count_next = count + CW'(1);
      default:   count_next = count;
    endcase
  end

  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    resident_next    = resident;
    op_q_next        = op_q;
    table_q_next     = table_q;
    offset_q_next    = offset_q;
    handle_q_next    = handle_q;
    charge_q_next    = charge_q;
    status_q_next    = status_q;
    hit_q_next       = hit_q;
    removed_next     = removed;
    out_valid_next   = out_valid && !rsp.ready;
    out_status_next  = out_status;
    out_hit_next     = out_hit;
    out_removed_next = out_removed;
    out_total_next   = out_total;
    act              = ACT_NONE;
    tgt              = '0;
    mem_raddr        = '0;
    mem_we           = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_q_next     = req.op;
          table_q_next  = req.table_id;
          offset_q_next = req.block_index;
          handle_q_next = req.block_handle;
          charge_q_next = req.charge;
          hit_q_next    = '0;
          removed_next  = '0;
          ptr_next      = '0;
          status_q_next = ST_MISS;
          state_next    = S_FINISH;
          case (req.op)
            OP_LOOKUP: begin
              if (capacity != '0) begin
                state_next = S_SCAN;
              end
            end
            OP_INSERT: begin
              if (capacity == '0 || req.block_handle == '0 || req.charge > capacity) begin
                status_q_next = ST_REJECTED;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_ERASE: begin
              status_q_next = ST_ERASED;
              if (capacity != '0) begin
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_raddr = ptr + IW'(1);
        tgt       = ptr;
        if (op_q == OP_ERASE) begin
          if (valid[ptr] && rd_table == table_q) begin
            act           = ACT_DROP;
            resident_next = resident - rd_charge;
            removed_next  = removed + COUNT_W'(1);
          end
          if (ptr == IW'(ENTRIES - 1)) begin
            state_next = S_FINISH;
          end else begin
            ptr_next = ptr + IW'(1);
          end
        end else if (valid[ptr] && rd_table == table_q && rd_offset == offset_q) begin
          act        = ACT_PROMOTE;
          state_next = S_FINISH;
          if (op_q == OP_LOOKUP) begin
            status_q_next = ST_HIT;
            hit_q_next    = rd_handle;
          end else begin
            status_q_next = ST_PRESENT;
          end
        end else if (ptr == IW'(ENTRIES - 1)) begin
          state_next = (op_q == OP_LOOKUP) ? S_FINISH : S_EVICT_CHK;
        end else begin
          ptr_next = ptr + IW'(1);
        end
      end
      S_EVICT_CHK: begin
        mem_raddr = lru_idx;
        if ((over && count != '0) || count == CW'(ENTRIES)) begin
          state_next = S_EVICT_DROP;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_EVICT_DROP: begin
        act           = ACT_DROP;
        tgt           = lru_idx;
        resident_next = resident - rd_charge;
        removed_next  = removed + COUNT_W'(1);
        state_next    = S_EVICT_CHK;
      end
      S_PLACE: begin
        mem_we        = 1'b1;
        act           = ACT_PLACE;
        tgt           = free_idx;
        resident_next = resident + charge_q;
        status_q_next = ST_INSERTED;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next   = 1'b1;
          out_status_next  = status_q;
          out_hit_next     = hit_q;
          out_removed_next = removed;
          out_total_next   = resident;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= '0;
      valid     <= '0;
      count     <= '0;
      resident  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      count     <= count_next;
      resident  <= resident_next;
      out_valid <= out_valid_next;
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rank        <= rank_next;
    ptr         <= ptr_next;
    op_q        <= op_q_next;
    table_q     <= table_q_next;
    offset_q    <= offset_q_next;
    handle_q    <= handle_q_next;
    charge_q    <= charge_q_next;
    status_q    <= status_q_next;
    hit_q       <= hit_q_next;
    removed     <= removed_next;
    out_status  <= out_status_next;
    out_hit     <= out_hit_next;
    out_removed <= out_removed_next;
    out_total   <= out_total_next;
  end

endmodule

FILE: sv/lbc_checker.sv
// Port checker for the block cache, bound to the top level.
// Depends on lbc_pkg and lru_block_cache_byte_charge.
module lbc_port_checker import lbc_pkg::*; #(
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    status,
  input logic [HANDLE_BITS-1:0] hit_handle,
  input logic [COUNT_W-1:0]     evicted_count,
  input logic [WORD_W-1:0]      charge_total
);

  a_handle_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_HIT |-> hit_handle == '0)
    else $error("handle returned without a hit");

  a_no_evict_on_lookup: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_MISS || status == ST_HIT || status == ST_PRESENT ||
                  status == ST_REJECTED) |-> evicted_count == '0)
    else $error("entries removed by a request that removes none");

  a_status_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_ERASED)
    else $error("response status outside the defined codes");

  a_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(charge_total) && $stable(status))
    else $error("response changed while stalled");

endmodule

bind lru_block_cache_byte_charge lbc_port_checker #(.HANDLE_BITS(HANDLE_BITS)) u_lbc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .status        (rsp.status),
  .hit_handle    (rsp.hit_handle),
  .evicted_count (rsp.evicted_count),
  .charge_total  (rsp.charge_total)
);
